FILE: src/qvr_pkg.sv
// Shared types and fixed widths for the quaternion vector rotation block.
// Used by the front end, the job queue, the back end and the top level.
`default_nettype none

package qvr_pkg;

  localparam int VEC_W      = 32;            // Q16.16 vector component
  localparam int QUAT_W     = 16;            // Q2.14 quaternion component
  localparam int PROD_W     = 2 * QUAT_W;    // quaternion product, Q.28
  localparam int ENT_W      = PROD_W + 2;    // matrix entry, Q.28
  localparam int HALF_W     = VEC_W / 2;     // vector split into halves
  localparam int HI_W       = ENT_W + HALF_W;       // entry * signed high half
  localparam int LO_W       = ENT_W + HALF_W + 1;   // entry * unsigned low half
  localparam int A_W        = HI_W + 2;      // sum of three high products
  localparam int C_W        = LO_W + 3;      // sum of three low products plus half
  localparam int X_W        = A_W + 1;
  localparam int ROUND_SHIFT = 28;           // product fraction bits above Q16.16
  localparam int R_W        = X_W - (ROUND_SHIFT - HALF_W);

  typedef logic signed [VEC_W-1:0]  vcomp_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ENT_W-1:0]  ent_t;

  typedef struct packed {
    vcomp_t x;
    vcomp_t y;
    vcomp_t z;
  } vec_t;

  typedef struct packed {
    prod_t ww;
    prod_t ii;
    prod_t jj;
    prod_t kk;
    prod_t ij;
    prod_t ik;
    prod_t jk;
    prod_t wi;
    prod_t wj;
    prod_t wk;
  } qprod_t;

  typedef ent_t [2:0][2:0] mat_t;

  typedef struct packed {
    vec_t v;
    mat_t m;
  } job_t;

endpackage

`default_nettype wire

FILE: src/qvr_front.sv
// Front end: takes input beats, forms the quaternion products and the
// rotation matrix, and hands a job to the queue. Depends on qvr_pkg.
`default_nettype none

module qvr_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [qvr_pkg::VEC_W-1:0]     vec_x_i,
  input  logic signed [qvr_pkg::VEC_W-1:0]     vec_y_i,
  input  logic signed [qvr_pkg::VEC_W-1:0]     vec_z_i,
  input  logic signed [qvr_pkg::QUAT_W-1:0]    quat_w_i,
  input  logic signed [qvr_pkg::QUAT_W-1:0]    quat_i_i,
  input  logic signed [qvr_pkg::QUAT_W-1:0]    quat_j_i,
  input  logic signed [qvr_pkg::QUAT_W-1:0]    quat_k_i,
  output logic                                 job_valid_o,
  input  logic                                 job_full_i,
  output qvr_pkg::job_t                        job_o
);
  import qvr_pkg::*;

  function automatic ent_t diag_sum(prod_t a, prod_t b, prod_t c, prod_t d);
    return ENT_W'(a) + ENT_W'(b) - ENT_W'(c) - ENT_W'(d);
  endfunction

  function automatic ent_t twice_add(prod_t a, prod_t b);
    return (ENT_W'(a) + ENT_W'(b)) <<< 1;
  endfunction

  function automatic ent_t twice_sub(prod_t a, prod_t b);
    return (ENT_W'(a) - ENT_W'(b)) <<< 1;
  endfunction

  logic   p_valid_q;
  qprod_t p_prod_q, p_prod_d;
  vec_t   p_vec_q;
  logic   m_valid_q;
  job_t   m_job_q, m_job_d;
  logic   p_rdy, m_rdy;

  assign m_rdy      = !m_valid_q || !job_full_i;
  assign p_rdy      = !p_valid_q || m_rdy;
  assign in_stall_o = !p_rdy;

  always_comb begin
    p_prod_d.ww = quat_w_i * quat_w_i;
    p_prod_d.ii = quat_i_i * quat_i_i;
    p_prod_d.jj = quat_j_i * quat_j_i;
    p_prod_d.kk = quat_k_i * quat_k_i;
    p_prod_d.ij = quat_i_i * quat_j_i;
    p_prod_d.ik = quat_i_i * quat_k_i;
    p_prod_d.jk = quat_j_i * quat_k_i;
    p_prod_d.wi = quat_w_i * quat_i_i;
    p_prod_d.wj = quat_w_i * quat_j_i;
    p_prod_d.wk = quat_w_i * quat_k_i;
  end

  always_comb begin
    m_job_d.v       = p_vec_q;
    m_job_d.m[0][0] = diag_sum(p_prod_q.ww, p_prod_q.ii, p_prod_q.jj, p_prod_q.kk);
    m_job_d.m[0][1] = twice_sub(p_prod_q.ij, p_prod_q.wk);
    m_job_d.m[0][2] = twice_add(p_prod_q.ik, p_prod_q.wj);
    m_job_d.m[1][0] = twice_add(p_prod_q.wk, p_prod_q.ij);
    m_job_d.m[1][1] = diag_sum(p_prod_q.ww, p_prod_q.jj, p_prod_q.ii, p_prod_q.kk);
    m_job_d.m[1][2] = twice_sub(p_prod_q.jk, p_prod_q.wi);
    m_job_d.m[2][0] = twice_sub(p_prod_q.ik, p_prod_q.wj);
    m_job_d.m[2][1] = twice_add(p_prod_q.wi, p_prod_q.jk);
    m_job_d.m[2][2] = diag_sum(p_prod_q.ww, p_prod_q.kk, p_prod_q.ii, p_prod_q.jj);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      if (p_rdy) p_valid_q <= in_valid_i;
      if (m_rdy) m_valid_q <= p_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_rdy && in_valid_i) begin
      p_prod_q <= p_prod_d;
      p_vec_q  <= '{x: vec_x_i, y: vec_y_i, z: vec_z_i};
    end
    // advance the matrix stage only when it can move on
    if (m_rdy && p_valid_q) m_job_q <= m_job_d;
  end

  assign job_valid_o = m_valid_q;
  assign job_o       = m_job_q;

endmodule

`default_nettype wire

FILE: src/qvr_fifo.sv
// Short job queue between the front and back ends, held in flops.
// Depends on qvr_pkg for the job type.
`default_nettype none

module qvr_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  qvr_pkg::job_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output qvr_pkg::job_t pop_data_o
);
  import qvr_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign valid_o    = (cnt_q != '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

`default_nettype wire

FILE: src/qvr_back.sv
// Back end: multiplies each matrix row by the vector in split halves,
// sums, rounds to Q16.16 and saturates. Depends on qvr_pkg.
`default_nettype none

module qvr_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              job_valid_i,
  output logic                              job_pop_o,
  input  qvr_pkg::job_t                     job_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [qvr_pkg::VEC_W-1:0]  rot_x_o,
  output logic signed [qvr_pkg::VEC_W-1:0]  rot_y_o,
  output logic signed [qvr_pkg::VEC_W-1:0]  rot_z_o,
  output logic                              saturated_o
);
  import qvr_pkg::*;

  localparam logic signed [C_W-1:0] RoundHalf = C_W'(1) <<< (ROUND_SHIFT - 1);

  logic                    s1_valid_q, s2_valid_q, s3_valid_q;
  logic                    s1_rdy, s2_rdy, s3_rdy;
  vcomp_t                  vc [3];
  logic signed [HI_W-1:0]  hi_d [3][3];
  logic signed [HI_W-1:0]  hi_q [3][3];
  logic signed [LO_W-1:0]  lo_d [3][3];
  logic signed [LO_W-1:0]  lo_q [3][3];
  logic signed [A_W-1:0]   a_d [3];
  logic signed [A_W-1:0]   a_q [3];
  logic signed [C_W-1:0]   c_d [3];
  logic signed [C_W-1:0]   c_q [3];
  logic signed [X_W-1:0]   x_sum [3];
  logic signed [R_W-1:0]   r_val [3];
  vcomp_t                  rot_d [3];
  vcomp_t                  rot_q [3];
  logic                    sat_d, sat_q;

  assign s3_rdy    = !s3_valid_q || !out_stall_i;
  assign s2_rdy    = !s2_valid_q || s3_rdy;
  assign s1_rdy    = !s1_valid_q || s2_rdy;
  assign job_pop_o = s1_rdy;

  assign vc[0] = job_i.v.x;
  assign vc[1] = job_i.v.y;
  assign vc[2] = job_i.v.z;

  // signed high half times entry, unsigned low half times entry
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        hi_d[r][k] = $signed(job_i.m[r][k]) * $signed(vc[k][VEC_W-1:HALF_W]);
        lo_d[r][k] = $signed(job_i.m[r][k]) * $signed({1'b0, vc[k][HALF_W-1:0]});
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      a_d[r] = A_W'(hi_q[r][0]) + A_W'(hi_q[r][1]) + A_W'(hi_q[r][2]);
      c_d[r] = C_W'(lo_q[r][0]) + C_W'(lo_q[r][1]) + C_W'(lo_q[r][2]) + RoundHalf;
    end
  end

  // fold the low sum into the high sum, drop fraction bits, clamp
  always_comb begin
    sat_d = 1'b0;
    for (int r = 0; r < 3; r++) begin
      x_sum[r] = X_W'(a_q[r]) + X_W'(c_q[r] >>> HALF_W);
      r_val[r] = x_sum[r][X_W-1:ROUND_SHIFT-HALF_W];
      rot_d[r] = r_val[r][VEC_W-1:0];
      if (!r_val[r][R_W-1] && (|r_val[r][R_W-2:VEC_W-1])) begin
        rot_d[r] = {1'b0, {(VEC_W-1){1'b1}}};
        sat_d    = 1'b1;
      end else if (r_val[r][R_W-1] && !(&r_val[r][R_W-2:VEC_W-1])) begin
        rot_d[r] = {1'b1, {(VEC_W-1){1'b0}}};
        sat_d    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (s1_rdy) s1_valid_q <= job_valid_i;
      if (s2_rdy) s2_valid_q <= s1_valid_q;
      if (s3_rdy) s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_rdy && job_valid_i) begin
      hi_q <= hi_d;
      lo_q <= lo_d;
    end
    if (s2_rdy && s1_valid_q) begin
      a_q <= a_d;
      c_q <= c_d;
    end
    // hold the result while the sink stalls
    if (s3_rdy && s2_valid_q) begin
      rot_q <= rot_d;
      sat_q <= sat_d;
    end
  end

  assign out_valid_o = s3_valid_q;
  assign rot_x_o     = rot_q[0];
  assign rot_y_o     = rot_q[1];
  assign rot_z_o     = rot_q[2];
  assign saturated_o = sat_q;

endmodule

`default_nettype wire

FILE: src/quaternion_vector_rotate_top.sv
// Top level of the quaternion vector rotation block.
// Instantiates qvr_front, qvr_fifo and qvr_back; depends on qvr_pkg.
`default_nettype none

// Rotates a Q16.16 vector by the matrix built from an unnormalized Q2.14
// quaternion and returns the result rounded to nearest (ties upward) and
// saturated to Q16.16, with a flag when any component clamps. One beat is
// accepted every cycle while in_stall_o is low and one result leaves every
// cycle while out_stall_i is low. A beat passes six registers: two front
// stages (quaternion products, matrix entries), an entry in the job queue,
// and three back stages (split multiplies, row sums, round and clamp, the
// last being the output register). The first stage loads at the accepting
// edge, and the beat then moves through the later registers in that order.
// The queue of QueueDepth jobs lets the front keep accepting for a while
// when the output is stalled; input stall rises only when the queue is full
// and both front stages hold beats, never straight from the output stall.
module quaternion_vector_rotate_top #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [qvr_pkg::VEC_W-1:0]  vec_x_i,
  input  logic signed [qvr_pkg::VEC_W-1:0]  vec_y_i,
  input  logic signed [qvr_pkg::VEC_W-1:0]  vec_z_i,
  input  logic signed [qvr_pkg::QUAT_W-1:0] quat_w_i,
  input  logic signed [qvr_pkg::QUAT_W-1:0] quat_i_i,
  input  logic signed [qvr_pkg::QUAT_W-1:0] quat_j_i,
  input  logic signed [qvr_pkg::QUAT_W-1:0] quat_k_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [qvr_pkg::VEC_W-1:0]  rot_x_o,
  output logic signed [qvr_pkg::VEC_W-1:0]  rot_y_o,
  output logic signed [qvr_pkg::VEC_W-1:0]  rot_z_o,
  output logic                              saturated_o
);
  import qvr_pkg::*;

  logic job_valid, job_full, q_valid, q_pop;
  job_t job, q_job;

  qvr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .vec_x_i     (vec_x_i),
    .vec_y_i     (vec_y_i),
    .vec_z_i     (vec_z_i),
    .quat_w_i    (quat_w_i),
    .quat_i_i    (quat_i_i),
    .quat_j_i    (quat_j_i),
    .quat_k_i    (quat_k_i),
    .job_valid_o (job_valid),
    .job_full_i  (job_full),
    .job_o       (job)
  );

  qvr_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (job_valid),
    .push_data_i (job),
    .full_o      (job_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_job)
  );

  qvr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_pop_o   (q_pop),
    .job_i       (q_job),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .rot_x_o     (rot_x_o),
    .rot_y_o     (rot_y_o),
    .rot_z_o     (rot_z_o),
    .saturated_o (saturated_o)
  );

endmodule

`default_nettype wire
